>>> hdl/ffbp_pkg.sv
// Package for the first-fit bin packer.
// Holds field widths, reset constants, error codes and the flag struct
// that moves between cells. No dependencies.
package ffbp_pkg;

    // Fixed widths of the item and result fields.
    localparam int SIZE_W  = 16;
    localparam int INDEX_W = 6;
    localparam int USED_W  = 7;
    localparam int ERR_W   = 2;

    // Capacity after reset.
    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd100;

    // Error codes of a result item.
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERSIZE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL     = 2'd2;

    // Status of an object as it travels down the row of cells.
    typedef struct packed {
        logic valid;     // a live object sits in this slot
        logic last;      // final object of a set; cells clear behind it
        logic oversize;  // larger than the capacity, never placed
        logic placed;    // some cell has taken the object
        logic opened;    // the cell that took it was opened for it
    } tok_flags_t;

endpackage

>>> hdl/ffbp_cell.sv
// One bin cell of the first-fit packer row.
// Holds the fill and open flag of one bin and passes the object on.
// Depends on ffbp_pkg.
module ffbp_cell
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS = 64,
    parameter int CELL_ID  = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [SIZE_W-1:0]              capacity,
    input  tok_flags_t                     flags_in,
    input  logic [SIZE_W-1:0]              size_in,
    input  logic [$clog2(MAX_BINS)-1:0]    index_in,
    input  logic [$clog2(MAX_BINS+1)-1:0]  count_in,
    output tok_flags_t                     flags_out,
    output logic [SIZE_W-1:0]              size_out,
    output logic [$clog2(MAX_BINS)-1:0]    index_out,
    output logic [$clog2(MAX_BINS+1)-1:0]  count_out
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    // Bin state.
    logic              open_reg, open_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;

    // Object slot handed to the next cell.
    tok_flags_t        flags_reg, flags_next;
    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [SIZE_W:0] sum;
    logic            fits;
    logic            take;
    logic            open_now;

    // Fit test: an open bin takes the object if fill plus size stays within capacity.
    assign sum  = {1'b0, fill_reg} + {1'b0, size_in};
    assign fits = open_reg && (sum <= {1'b0, capacity});
    assign take = flags_in.valid && !flags_in.oversize && !flags_in.placed
                  && (fits || !open_reg);
    assign open_now = open_reg || take;

    // Update of the object slot.
    always_comb begin
        flags_next        = flags_in;
        flags_next.placed = flags_in.placed || take;
        flags_next.opened = flags_in.opened || (take && !open_reg);
        index_next        = take ? IDX_W'(CELL_ID) : index_in;
        count_next        = count_in + CNT_W'(open_now);
    end

    // Update of the bin; a last object clears the bin once it has passed.
    always_comb begin
        open_next = open_reg;
        fill_next = fill_reg;
        if (flags_in.valid) begin
            if (flags_in.last) begin
                open_next = 1'b0;
                fill_next = '0;
            end else if (take) begin
                open_next = 1'b1;
                fill_next = open_reg ? sum[SIZE_W-1:0] : size_in;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            flags_reg <= '0;
        end else if (advance) begin
            open_reg  <= open_next;
            flags_reg <= flags_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance) begin
            fill_reg  <= fill_next;
            size_reg  <= size_in;
            index_reg <= index_next;
            count_reg <= count_next;
        end
    end

    assign flags_out = flags_reg;
    assign size_out  = size_reg;
    assign index_out = index_reg;
    assign count_out = count_reg;

endmodule

>>> hdl/ffbp_result.sv
// Result stage of the first-fit packer.
// Encodes the error code, fits indexes to the field widths and holds the
// result item until it is taken. Depends on ffbp_pkg.
module ffbp_result
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tok_flags_t                     flags_in,
    input  logic [$clog2(MAX_BINS)-1:0]    index_in,
    input  logic [$clog2(MAX_BINS+1)-1:0]  count_in,
    output logic                           advance,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [INDEX_W-1:0]             m_bin_index,
    output logic                           m_opened_new,
    output logic [USED_W-1:0]              m_bins_used,
    output logic [ERR_W-1:0]               m_error_code,
    output logic                           m_set_done
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic                  valid_reg;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic                  opened_reg;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic                  done_reg;
    logic [IDX_W+INDEX_W-1:0] index_ext;
    logic [CNT_W+USED_W-1:0]  count_ext;

    // The whole row moves whenever the output slot is free or being emptied.
    assign advance = !valid_reg || m_ready;

    // Widen, then keep the low bits of each field.
    assign index_ext  = {{INDEX_W{1'b0}}, index_in};
    assign count_ext  = {{USED_W{1'b0}}, count_in};
    assign index_next = index_ext[INDEX_W-1:0];
    assign used_next  = count_ext[USED_W-1:0];

    // Error code from the object's flags.
    always_comb begin
        if (flags_in.oversize) begin
            err_next = ERR_OVERSIZE;
        end else if (!flags_in.placed) begin
            err_next = ERR_FULL;
        end else begin
            err_next = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= flags_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            index_reg  <= index_next;
            opened_reg <= flags_in.opened;
            used_reg   <= used_next;
            err_reg    <= err_next;
            done_reg   <= flags_in.last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_bin_index  = index_reg;
    assign m_opened_new = opened_reg;
    assign m_bins_used  = used_reg;
    assign m_error_code = err_reg;
    assign m_set_done   = done_reg;

    // A new bin is only reported for a placed object.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && opened_reg |-> err_reg == ERR_NONE)
        else $error("opened bin reported with an error");

    // A failed object always reports bin zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && err_reg != ERR_NONE |-> index_reg == '0)
        else $error("nonzero bin index on error");

    // A placed object lands in a bin that is counted as open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && err_reg == ERR_NONE && MAX_BINS <= 64
        |-> {1'b0, index_reg} < used_reg)
        else $error("bin index beyond the open bins");

endmodule

>>> hdl/first_fit_bin_packer_unit.sv
// Top level of the first-fit bin packer: a row of bin cells and a result stage.
// Depends on ffbp_pkg, ffbp_cell and ffbp_result.
//
//   port group   dir   handshake              payload
//   s_           in    s_valid / s_ready      s_item_size, s_last_item
//   m_           out   m_valid / m_ready      m_bin_index, m_opened_new,
//                                             m_bins_used, m_error_code, m_set_done
//   cfg_         in    cfg_valid / cfg_ready  cfg_wdata (bin capacity)
//
// An object moves one cell per cycle while the row advances, then into the result
// register; unless the row stalls, it takes a new item every cycle.
// The length of the cell row sets the latency; each cell does one add and compare.
// When a result is held with m_ready low, the whole row stalls and s_ready drops.
// Reset closes all bins and sets the capacity to 100; no clearing pass is needed.
module first_fit_bin_packer_unit
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SIZE_W-1:0]    s_item_size,
    input  logic                 s_last_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [INDEX_W-1:0]   m_bin_index,
    output logic                 m_opened_new,
    output logic [USED_W-1:0]    m_bins_used,
    output logic [ERR_W-1:0]     m_error_code,
    output logic                 m_set_done,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [SIZE_W-1:0] cap_reg;
    logic              advance;

    // Links between cells; link 0 is the incoming item.
    tok_flags_t        flags_link [MAX_BINS+1];
    logic [SIZE_W-1:0] size_link  [MAX_BINS+1];
    logic [IDX_W-1:0]  index_link [MAX_BINS+1];
    logic [CNT_W-1:0]  count_link [MAX_BINS+1];

    // Capacity register; writes are taken at any time.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign s_ready = advance;

    // Build the object entering the first cell.
    always_comb begin
        flags_link[0].valid    = s_valid;
        flags_link[0].last     = s_last_item;
        flags_link[0].oversize = s_item_size > cap_reg;
        flags_link[0].placed   = 1'b0;
        flags_link[0].opened   = 1'b0;
    end
    assign size_link[0]  = s_item_size;
    assign index_link[0] = '0;
    assign count_link[0] = '0;

    // Row of bin cells.
    for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
        ffbp_cell #(
            .MAX_BINS (MAX_BINS),
            .CELL_ID  (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .capacity  (cap_reg),
            .flags_in  (flags_link[i]),
            .size_in   (size_link[i]),
            .index_in  (index_link[i]),
            .count_in  (count_link[i]),
            .flags_out (flags_link[i+1]),
            .size_out  (size_link[i+1]),
            .index_out (index_link[i+1]),
            .count_out (count_link[i+1])
        );
    end

    // Result stage; the size is not needed past the last cell.
    ffbp_result #(
        .MAX_BINS (MAX_BINS)
    ) u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .flags_in     (flags_link[MAX_BINS]),
        .index_in     (index_link[MAX_BINS]),
        .count_in     (count_link[MAX_BINS]),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_opened_new (m_opened_new),
        .m_bins_used  (m_bins_used),
        .m_error_code (m_error_code),
        .m_set_done   (m_set_done)
    );

endmodule

>>> verif/ffbp_placement_checker.sv
`timescale 1ns / 100ps
// Placement checker for the first-fit bin packer: it predicts every result item
// from the accepted items and the written capacity, then compares them in order.
// Depends on ffbp_pkg.
module ffbp_placement_checker
    import ffbp_pkg::*;
#(
    parameter int BIN_SLOTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [SIZE_W-1:0]    s_item_size,
    input  logic                 s_last_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [INDEX_W-1:0]   m_bin_index,
    input  logic                 m_opened_new,
    input  logic [USED_W-1:0]    m_bins_used,
    input  logic [ERR_W-1:0]     m_error_code,
    input  logic                 m_set_done,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    output int                   fail_count,
    output int                   outstanding
);

    // One predicted result item.
    typedef struct packed {
        logic [INDEX_W-1:0] bin_index;
        logic               opened_new;
        logic [USED_W-1:0]  bins_used;
        logic [ERR_W-1:0]   error_code;
        logic               set_done;
    } placement_t;

    // Our own copy of the bin table and the capacity register.
    logic [SIZE_W-1:0] fill_level [BIN_SLOTS];
    int unsigned       bins_open;
    logic [SIZE_W-1:0] capacity;

    placement_t placement_q [$];

    // First-fit placement of one object; updates the bin table.
    function automatic placement_t place_object(logic [SIZE_W-1:0] size, logic last);
        placement_t  res;
        int unsigned slot;
        bit          found;
        res = '0;
        res.set_done = last;
        found = 1'b0;
        slot = 0;
        if (int'(size) > int'(capacity)) begin
            res.error_code = ERR_OVERSIZE;
        end else begin
            for (int unsigned b = 0; b < bins_open && !found; b++) begin
                if (int'(fill_level[b]) + int'(size) <= int'(capacity)) begin
                    found = 1'b1;
                    slot = b;
                end
            end
            if (found) begin
                fill_level[slot] = fill_level[slot] + size;
            end else if (bins_open < BIN_SLOTS) begin
                slot = bins_open;
                fill_level[slot] = size;
                bins_open++;
                res.opened_new = 1'b1;
            end else begin
                res.error_code = ERR_FULL;
            end
        end
        // An error result reports bin 0.
        res.bin_index = (res.error_code == ERR_NONE) ? INDEX_W'(slot) : '0;
        res.bins_used = USED_W'(bins_open);
        // The last item of a set closes every bin after its result.
        if (last) begin
            for (int b = 0; b < BIN_SLOTS; b++) begin
                fill_level[b] = '0;
            end
            bins_open = 0;
        end
        return res;
    endfunction

    function automatic int field_mismatch(string field, logic [7:0] want, logic [7:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            return 1;
        end
        return 0;
    endfunction

    // Compare results first, then record the item taken at the same edge.
    always @(posedge aclk) begin : track
        placement_t want;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            for (int b = 0; b < BIN_SLOTS; b++) begin
                fill_level[b] = '0;
            end
            bins_open = 0;
            capacity = CAP_RESET;
            placement_q.delete();
            fail_count <= 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (placement_q.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    errs++;
                end else begin
                    want = placement_q.pop_front();
                    errs += field_mismatch("bin_index", want.bin_index, m_bin_index);
                    errs += field_mismatch("opened_new", want.opened_new, m_opened_new);
                    errs += field_mismatch("bins_used", want.bins_used, m_bins_used);
                    errs += field_mismatch("error_code", want.error_code, m_error_code);
                    errs += field_mismatch("set_done", want.set_done, m_set_done);
                end
            end
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                placement_q.push_back(place_object(s_item_size, s_last_item));
            end
            fail_count <= fail_count + errs;
            outstanding <= placement_q.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for first_fit_bin_packer_unit: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on ffbp_pkg and ffbp_placement_checker.
module tb;
    import ffbp_pkg::*;

    localparam int BIN_SLOTS   = 64;
    localparam int PIPE_LAT    = BIN_SLOTS + 1;
    localparam int WATCHDOG    = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 200;

    typedef enum {SET_PLAIN, SET_FLOOD, SET_NOISE, SET_BAD_END} set_kind_t;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [SIZE_W-1:0]   s_item_size  = '0;
    logic                s_last_item  = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [INDEX_W-1:0]  m_bin_index;
    logic                m_opened_new;
    logic [USED_W-1:0]   m_bins_used;
    logic [ERR_W-1:0]    m_error_code;
    logic                m_set_done;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_wdata    = '0;

    int                  fail_count;
    int                  outstanding;
    int unsigned         send_idle_pct = 33;
    int unsigned         recv_idle_pct = 72;
    logic                hold_go       = 1'b0;

    first_fit_bin_packer_unit #(
        .MAX_BINS(BIN_SLOTS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_size  (s_item_size),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_opened_new (m_opened_new),
        .m_bins_used  (m_bins_used),
        .m_error_code (m_error_code),
        .m_set_done   (m_set_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata)
    );

    ffbp_placement_checker #(
        .BIN_SLOTS(BIN_SLOTS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_size  (s_item_size),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_opened_new (m_opened_new),
        .m_bins_used  (m_bins_used),
        .m_error_code (m_error_code),
        .m_set_done   (m_set_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off whenever hold_go toggles.
    always @(posedge aclk) begin : receiver
        static int  hold_left = 0;
        static bit  hold_ack  = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_go != hold_ack) begin
            m_ready <= 1'b0;
            hold_ack = hold_go;
            hold_left = LONG_HOLD;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Ends the run when nothing at all is accepted for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic offer_object(input logic [SIZE_W-1:0] size, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_item_size <= size;
        s_last_item <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops offering until every outstanding result item has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Writes the capacity while the block is idle.
    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        drain_results();
        repeat (PIPE_LAT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        set_kind_t         kind;
        int unsigned       len;
        int unsigned       sent;
        int unsigned       cap;
        int unsigned       pick;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] phase_cap [NUM_PHASES];

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items at the reset capacity of 100: empty bins, exact fits,
        // new bins, oversized objects and a last item that carries an error.
        offer_object(16'd0, 1'b0);
        offer_object(16'd0, 1'b0);
        offer_object(16'd100, 1'b0);
        offer_object(16'd1, 1'b0);
        offer_object(16'd99, 1'b0);
        offer_object(16'd50, 1'b0);
        offer_object(16'd50, 1'b0);
        offer_object(16'd101, 1'b0);
        offer_object(16'hFFFF, 1'b0);
        offer_object(16'hFFFF, 1'b1);
        offer_object(16'd100, 1'b1);

        // Largest capacity: sums that would overflow 16 bits must not fit.
        write_capacity(16'hFFFF);
        offer_object(16'hFFFF, 1'b0);
        offer_object(16'hFFFF, 1'b0);
        offer_object(16'd0, 1'b0);
        offer_object(16'd1, 1'b0);
        offer_object(16'h8000, 1'b0);
        offer_object(16'h7FFF, 1'b1);

        // Smallest capacity.
        write_capacity(16'd1);
        offer_object(16'd2, 1'b0);
        offer_object(16'd1, 1'b0);
        offer_object(16'd0, 1'b0);
        offer_object(16'd1, 1'b1);

        phase_cap[0] = 16'd100;
        phase_cap[1] = 16'hFFFF;
        phase_cap[2] = 16'd1;
        phase_cap[3] = SIZE_W'($urandom_range(2, 300));
        phase_cap[4] = SIZE_W'($urandom_range(1, 65535));
        phase_cap[5] = 16'd2;
        phase_cap[6] = SIZE_W'($urandom_range(1, 65535));

        // Random sets; each phase opens with a flood that can overrun the bin table.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 33;
                recv_idle_pct <= 72;
            end else if (ph < 4) begin
                send_idle_pct = 72;
                recv_idle_pct <= 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            write_capacity(phase_cap[ph]);
            cap = phase_cap[ph];
            sent = 0;
            kind = SET_FLOOD;
            while (sent < PHASE_ITEMS) begin
                case (kind)
                    SET_PLAIN:   len = $urandom_range(1, 20);
                    SET_FLOOD:   len = $urandom_range(60, 72);
                    SET_NOISE:   len = $urandom_range(1, 8);
                    default:     len = $urandom_range(2, 12);
                endcase
                for (int unsigned k = 0; k < len; k++) begin
                    case (kind)
                        SET_FLOOD:   size = SIZE_W'($urandom_range(cap / 2 + 1, cap));
                        SET_NOISE:   size = SIZE_W'($urandom_range(0, 65535));
                        default: begin
                            if ($urandom_range(0, 3) == 0)
                                size = SIZE_W'($urandom_range(0, cap / 8));
                            else
                                size = SIZE_W'($urandom_range(0, cap));
                        end
                    endcase
                    // Below the top capacity, a broken set ends on an oversized object.
                    if (kind == SET_BAD_END && k == len - 1 && cap < 65535)
                        size = SIZE_W'($urandom_range(cap + 1, 65535));
                    offer_object(size, k == len - 1);
                    sent++;
                    if (ph == 0 && sent == 40)
                        hold_go <= ~hold_go;
                    if (ph == 3 && sent == 100)
                        drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    kind = SET_PLAIN;
                else if (pick < 75)
                    kind = SET_FLOOD;
                else if (pick < 90)
                    kind = SET_NOISE;
                else
                    kind = SET_BAD_END;
            end
        end

        drain_results();
        repeat (2 * PIPE_LAT) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
